// ----- rtl/aaq_pkg.sv -----
`default_nettype none

package aaq_pkg;

	// CORDIC datapath: Q2.30 with headroom for the quadrant fold
	localparam int CORDIC_W = 34;
	localparam int ATAN_LEN = 32;

	localparam logic signed [CORDIC_W-1:0] Q30_HALF_PI  = 34'sd1686629713;
	localparam logic signed [CORDIC_W-1:0] Q30_PI       = 34'sd3373259426;
	localparam logic signed [CORDIC_W-1:0] Q30_GAIN_INV = 34'sd652032874;

	// atan(2^-i), rounded, Q2.30
	localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
		32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
		32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
		32'd262144,    32'd131072,    32'd65536,     32'd32768,
		32'd16384,     32'd8192,      32'd4096,      32'd2048,
		32'd1024,      32'd512,       32'd256,       32'd128,
		32'd64,        32'd32,        32'd16,        32'd8,
		32'd4,         32'd2,         32'd1,         32'd0
	};

	// normalised squared length and its root
	localparam int RAD_W  = 64;
	localparam int ROOT_W = 32;

endpackage

`default_nettype wire

// ----- rtl/aaq_cordic.sv -----
`default_nettype none

module aaq_cordic #(
	parameter int W      = 16,
	parameter int STEPS  = 16,
	parameter int TAG_W  = 48
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   en,
	input  wire                                   in_valid,
	input  wire  signed [W-1:0]                   angle,
	input  wire         [TAG_W-1:0]               in_tag,
	output logic                                  out_valid,
	output logic signed [aaq_pkg::CORDIC_W-1:0]   sin_q30,
	output logic signed [aaq_pkg::CORDIC_W-1:0]   cos_q30,
	output logic        [TAG_W-1:0]               out_tag
);

	localparam int CW = aaq_pkg::CORDIC_W;

	logic [STEPS:0]          v_s;
	logic signed [CW-1:0]    x_s   [STEPS+1];
	logic signed [CW-1:0]    y_s   [STEPS+1];
	logic signed [CW-1:0]    z_s   [STEPS+1];
	logic                    neg_s [STEPS+1];
	logic [TAG_W-1:0]        tag_s [STEPS+1];

	logic signed [CW-1:0] h;
	logic signed [CW-1:0] zf;
	logic                 negf;

	// half angle: Q3.13 angle read directly as Q2.30 of angle/2
	assign h = CW'(angle) <<< (32 - W);

	// fold beyond +-pi/2; sine kept, cosine negated
	always_comb begin
		zf   = h;
		negf = 1'b0;
		if (h > aaq_pkg::Q30_HALF_PI) begin
			zf   = aaq_pkg::Q30_PI - h;
			negf = 1'b1;
		end else if (h < -aaq_pkg::Q30_HALF_PI) begin
			zf   = -aaq_pkg::Q30_PI - h;
			negf = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[STEPS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= aaq_pkg::Q30_GAIN_INV;
			y_s[0]   <= '0;
			z_s[0]   <= zf;
			neg_s[0] <= negf;
			tag_s[0] <= in_tag;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_it
		logic signed [CW-1:0] dx, dy, at;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign at = $signed(CW'(aaq_pkg::ATAN_Q30[i]));

		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end
				neg_s[i+1] <= neg_s[i];
				tag_s[i+1] <= tag_s[i];
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign sin_q30   = y_s[STEPS];
	assign cos_q30   = neg_s[STEPS] ? -x_s[STEPS] : x_s[STEPS];
	assign out_tag   = tag_s[STEPS];

endmodule

`default_nettype wire

// ----- rtl/aaq_sqrt.sv -----
`default_nettype none

module aaq_sqrt #(
	parameter int TAG_W = 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              en,
	input  wire                              in_valid,
	input  wire  [aaq_pkg::RAD_W-1:0]        rad,
	input  wire  [TAG_W-1:0]                 in_tag,
	output logic                             out_valid,
	output logic [aaq_pkg::ROOT_W-1:0]       root,
	output logic [TAG_W-1:0]                 out_tag
);

	localparam int N = aaq_pkg::ROOT_W;

	logic [N:0]         v_s;
	logic [2*N-1:0]     rest_s [N+1];
	logic [N+3:0]       rem_s  [N+1];
	logic [N-1:0]       root_s [N+1];
	logic [TAG_W-1:0]   tag_s  [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[N-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rest_s[0] <= rad;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			tag_s[0]  <= in_tag;
		end
	end

	// one result bit per stage, two radicand bits brought down each time
	for (genvar j = 0; j < N; j++) begin : g_bit
		logic [N+3:0] rsh, trial;

		assign rsh   = {rem_s[j][N+1:0], rest_s[j][2*N-1 -: 2]};
		assign trial = (N+4)'({root_s[j], 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				if (rsh >= trial) begin
					rem_s[j+1]  <= rsh - trial;
					root_s[j+1] <= {root_s[j][N-2:0], 1'b1};
				end else begin
					rem_s[j+1]  <= rsh;
					root_s[j+1] <= {root_s[j][N-2:0], 1'b0};
				end
				rest_s[j+1] <= rest_s[j] << 2;
				tag_s[j+1]  <= tag_s[j];
			end
		end
	end

	assign out_valid = v_s[N];
	assign root      = root_s[N];
	assign out_tag   = tag_s[N];

endmodule

`default_nettype wire

// ----- rtl/aaq_div.sv -----
`default_nettype none

module aaq_div #(
	parameter int W     = 16,
	parameter int TAG_W = 8
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              en,
	input  wire                              in_valid,
	input  wire  [W+29:0]                    num_x,
	input  wire  [W+29:0]                    num_y,
	input  wire  [W+29:0]                    num_z,
	input  wire  [aaq_pkg::ROOT_W-1:0]       len,
	input  wire  [TAG_W-1:0]                 in_tag,
	output logic                             out_valid,
	output logic [W-1:0]                     quo_x,
	output logic [W-1:0]                     quo_y,
	output logic [W-1:0]                     quo_z,
	output logic [TAG_W-1:0]                 out_tag
);

	localparam int DN = W + 30;
	localparam int LW = aaq_pkg::ROOT_W;

	logic [DN-1:0]      num_a [3];
	logic [W:0]         v_s;
	logic [LW-1:0]      len_s  [W+1];
	logic [LW-1:0]      rem_s  [W+1][3];
	logic [W-1:0]       rest_s [W+1][3];
	logic [W-1:0]       quo_s  [W+1][3];
	logic [TAG_W-1:0]   tag_s  [W+1];

	assign num_a[0] = num_x;
	assign num_a[1] = num_y;
	assign num_a[2] = num_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[W-1:0], in_valid};
		end
	end

	// upper dividend bits start as partial remainder; with the top-level inputs, below the divisor unless it is zero
	always_ff @(posedge clk) begin
		if (en) begin
			len_s[0] <= len;
			tag_s[0] <= in_tag;
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l]  <= LW'(num_a[l][DN-1:W]);
				rest_s[0][l] <= num_a[l][W-1:0];
				quo_s[0][l]  <= '0;
			end
		end
	end

	for (genvar j = 0; j < W; j++) begin : g_bit
		logic [LW:0] rsh [3];

		for (genvar l = 0; l < 3; l++) begin : g_lane
			assign rsh[l] = {rem_s[j][l], rest_s[j][l][W-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					if (rsh[l] >= {1'b0, len_s[j]}) begin
						rem_s[j+1][l] <= LW'(rsh[l] - {1'b0, len_s[j]});
						quo_s[j+1][l] <= {quo_s[j][l][W-2:0], 1'b1};
					end else begin
						rem_s[j+1][l] <= rsh[l][LW-1:0];
						quo_s[j+1][l] <= {quo_s[j][l][W-2:0], 1'b0};
					end
					rest_s[j+1][l] <= rest_s[j][l] << 1;
				end
				len_s[j+1] <= len_s[j];
				tag_s[j+1] <= tag_s[j];
			end
		end
	end

	assign out_valid = v_s[W];
	assign quo_x     = quo_s[W][0];
	assign quo_y     = quo_s[W][1];
	assign quo_z     = quo_s[W][2];
	assign out_tag   = tag_s[W];

endmodule

`default_nettype wire

// ----- rtl/axis_angle_to_quaternion_top.sv -----
// Throughput: one item per cycle unless the pipe halts; the stages are the CORDIC
// iterations, a 32-stage square root (one root bit each) and a DATA_WIDTH-stage divider
// (one quotient bit each). A two-entry output buffer takes results while the consumer
// stalls; the pipe halts only when both entries are full.
// Reset: arst_n clears all valid bits and the buffer count; no data registers are reset.
`default_nettype none

module axis_angle_to_quaternion_top #(
	parameter int DATA_WIDTH   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  signed [DATA_WIDTH-1:0] axis_x,
	input  wire  signed [DATA_WIDTH-1:0] axis_y,
	input  wire  signed [DATA_WIDTH-1:0] axis_z,
	input  wire  signed [DATA_WIDTH-1:0] angle,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic signed [DATA_WIDTH-1:0] quat_x,
	output logic signed [DATA_WIDTH-1:0] quat_y,
	output logic signed [DATA_WIDTH-1:0] quat_z,
	output logic signed [DATA_WIDTH-1:0] quat_w,
	output logic                         zero_axis
);

	localparam int W  = DATA_WIDTH;
	localparam int CW = aaq_pkg::CORDIC_W;
	localparam int DN = W + 30;
	localparam int PW = W + CW;
	localparam int RW = aaq_pkg::RAD_W;
	localparam int LW = aaq_pkg::ROOT_W;
	localparam int SH = 32 - W;

	localparam logic signed [PW-1:0] ONE_P = PW'(1) <<< (W - 2);
	localparam logic signed [PW-1:0] RND_P = PW'(1) <<< 29;

	typedef struct packed {
		logic                 zero;
		logic [2:0]           neg;
		logic [W-1:0]         mag_x;
		logic [W-1:0]         mag_y;
		logic [W-1:0]         mag_z;
		logic signed [CW-1:0] sin_v;
		logic signed [CW-1:0] cos_v;
	} side_t;

	typedef struct packed {
		side_t      side;
		logic [4:0] k;
	} nside_t;

	localparam int TAG_C = 3 * W;
	localparam int TAG_S = $bits(nside_t);
	localparam int TAG_D = $bits(side_t);

	function automatic logic signed [W-1:0] sat_unit(input logic signed [PW-1:0] v);
		if (v > ONE_P) begin
			return W'(ONE_P);
		end else if (v < -ONE_P) begin
			return W'(-ONE_P);
		end
		return v[W-1:0];
	endfunction

	logic en;

	// ---- sine / cosine of the half angle
	logic                 c_valid;
	logic signed [CW-1:0] c_sin, c_cos;
	logic [TAG_C-1:0]     c_tag;

	aaq_cordic #(
		.W     (W),
		.STEPS (CORDIC_STEPS),
		.TAG_W (TAG_C)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.angle     (angle),
		.in_tag    ({axis_x, axis_y, axis_z}),
		.out_valid (c_valid),
		.sin_q30   (c_sin),
		.cos_q30   (c_cos),
		.out_tag   (c_tag)
	);

	// ---- magnitudes and squares
	logic signed [W-1:0] cx, cy, cz;
	logic [W-1:0]        mx, my, mz;

	assign {cx, cy, cz} = c_tag;
	assign mx = $unsigned(cx[W-1] ? -cx : cx);
	assign my = $unsigned(cy[W-1] ? -cy : cy);
	assign mz = $unsigned(cz[W-1] ? -cz : cz);

	logic               v_sq;
	logic [2*W-1:0]     sqx_sq, sqy_sq, sqz_sq;
	side_t              side_sq;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_sq        <= (2*W)'(mx) * (2*W)'(mx);
			sqy_sq        <= (2*W)'(my) * (2*W)'(my);
			sqz_sq        <= (2*W)'(mz) * (2*W)'(mz);
			side_sq.zero  <= (mx | my | mz) == '0;
			side_sq.neg   <= {cx[W-1], cy[W-1], cz[W-1]};
			side_sq.mag_x <= mx;
			side_sq.mag_y <= my;
			side_sq.mag_z <= mz;
			side_sq.sin_v <= c_sin;
			side_sq.cos_v <= c_cos;
		end
	end

	// ---- sum of squares, then normalise by 4^k into [2^60, 2^62)
	logic [5:0]    v_n;
	logic [RW-1:0] sn_s   [6];
	logic [4:0]    k_s    [6];
	side_t         side_n [6];

	always_ff @(posedge clk) begin
		if (en) begin
			sn_s[0]   <= RW'(sqx_sq) + RW'(sqy_sq) + RW'(sqz_sq);
			k_s[0]    <= '0;
			side_n[0] <= side_sq;
		end
	end

	for (genvar n = 0; n < 5; n++) begin : g_norm
		localparam int M = 16 >> n;

		always_ff @(posedge clk) begin
			if (en) begin
				if (sn_s[n][RW-1:62-2*M] == '0) begin
					sn_s[n+1] <= sn_s[n] << (2 * M);
					k_s[n+1]  <= k_s[n] | 5'(M);
				end else begin
					sn_s[n+1] <= sn_s[n];
					k_s[n+1]  <= k_s[n];
				end
				side_n[n+1] <= side_n[n];
			end
		end
	end

	// ---- square root
	nside_t          ns_in, r_side;
	logic            r_valid;
	logic [LW-1:0]   r_root;
	logic [TAG_S-1:0] r_tag;

	assign ns_in.side = side_n[5];
	assign ns_in.k    = k_s[5];
	assign r_side     = r_tag;

	aaq_sqrt #(
		.TAG_W (TAG_S)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_n[5]),
		.rad       (sn_s[5]),
		.in_tag    (ns_in),
		.out_valid (r_valid),
		.root      (r_root),
		.out_tag   (r_tag)
	);

	// ---- dividends: |c| * 2^(W-2+k) + L/2, for round-half-up
	logic [DN-1:0] half_l, nx, ny, nz;

	assign half_l = DN'(r_root >> 1);
	assign nx = ((DN'(r_side.side.mag_x) << (W - 2)) << r_side.k) + half_l;
	assign ny = ((DN'(r_side.side.mag_y) << (W - 2)) << r_side.k) + half_l;
	assign nz = ((DN'(r_side.side.mag_z) << (W - 2)) << r_side.k) + half_l;

	logic             d_valid;
	logic [W-1:0]     quo_x, quo_y, quo_z;
	logic [TAG_D-1:0] d_tag;
	side_t            d_side;

	aaq_div #(
		.W     (W),
		.TAG_W (TAG_D)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_valid),
		.num_x     (nx),
		.num_y     (ny),
		.num_z     (nz),
		.len       (r_root),
		.in_tag    (r_side.side),
		.out_valid (d_valid),
		.quo_x     (quo_x),
		.quo_y     (quo_y),
		.quo_z     (quo_z),
		.out_tag   (d_tag)
	);

	assign d_side = d_tag;

	// ---- scale unit axis by the sine
	logic signed [W-1:0] ux, uy, uz;

	assign ux = d_side.neg[2] ? -$signed(quo_x) : $signed(quo_x);
	assign uy = d_side.neg[1] ? -$signed(quo_y) : $signed(quo_y);
	assign uz = d_side.neg[0] ? -$signed(quo_z) : $signed(quo_z);

	logic                 v_sm;
	logic signed [PW-1:0] px_sm, py_sm, pz_sm;
	logic signed [CW-1:0] cos_sm;
	logic                 zero_sm;

	always_ff @(posedge clk) begin
		if (en) begin
			px_sm   <= PW'(ux) * PW'(d_side.sin_v);
			py_sm   <= PW'(uy) * PW'(d_side.sin_v);
			pz_sm   <= PW'(uz) * PW'(d_side.sin_v);
			cos_sm  <= d_side.cos_v;
			zero_sm <= d_side.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq <= 1'b0;
			v_n  <= '0;
			v_sm <= 1'b0;
		end else if (en) begin
			v_sq <= c_valid;
			v_n  <= {v_n[4:0], v_sq};
			v_sm <= d_valid;
		end
	end

	// ---- round, saturate, identity on a zero axis
	logic signed [PW-1:0] rx, ry, rz, rw;
	logic signed [W-1:0]  fx, fy, fz, fw;

	assign rx = (px_sm + RND_P) >>> 30;
	assign ry = (py_sm + RND_P) >>> 30;
	assign rz = (pz_sm + RND_P) >>> 30;

	if (SH == 0) begin : g_cos_full
		assign rw = PW'(cos_sm);
	end else begin : g_cos_rnd
		assign rw = (PW'(cos_sm) + (PW'(1) <<< (SH - 1))) >>> SH;
	end

	assign fx = zero_sm ? '0 : sat_unit(rx);
	assign fy = zero_sm ? '0 : sat_unit(ry);
	assign fz = zero_sm ? '0 : sat_unit(rz);
	assign fw = zero_sm ? W'(ONE_P) : sat_unit(rw);

	// ---- two-entry output buffer
	logic signed [W-1:0] ox_q [2];
	logic signed [W-1:0] oy_q [2];
	logic signed [W-1:0] oz_q [2];
	logic signed [W-1:0] ow_q [2];
	logic                of_q [2];
	logic                wr_q, rd_q;
	logic [1:0]          cnt_q;
	logic                push, pop;

	assign en   = cnt_q != 2'd2;
	assign push = en & v_sm;
	assign pop  = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ox_q[wr_q] <= fx;
			oy_q[wr_q] <= fy;
			oz_q[wr_q] <= fz;
			ow_q[wr_q] <= fw;
			of_q[wr_q] <= zero_sm;
		end
	end

	assign in_ready  = en;
	assign out_valid = cnt_q != 2'd0;
	assign quat_x    = ox_q[rd_q];
	assign quat_y    = oy_q[rd_q];
	assign quat_z    = oz_q[rd_q];
	assign quat_w    = ow_q[rd_q];
	assign zero_axis = of_q[rd_q];

endmodule

`default_nettype wire
